// ===== sv/sadt_pkg.sv =====
package sadt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam int FUNC_W   = 3;
    localparam int SHORT_W  = 16;
    localparam int EXT_W    = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    localparam int IN_FIELDS_W  = FUNC_W + SHORT_W + EXT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + SHORT_W + EXT_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [SHORT_W-1:0] BASE_RESET = 16'h0001;
    localparam logic [EXT_W-1:0]   NULL_EXT   = '0;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT_USED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EXT_USED   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_NULL       = 3'd6;

endpackage

// ===== sv/sadt_slot_mem.sv =====
module sadt_slot_mem
    import sadt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [EXT_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [EXT_W-1:0] wr_data,
    output logic             init_done
);

    logic [EXT_W-1:0] slot_mem [TABLE_DEPTH];
    logic [EXT_W-1:0] rd_data_reg;
    logic [CNT_W-1:0] clr_cnt_reg;
    logic             clearing;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [EXT_W-1:0] mem_wdata;

    // After reset every slot is swept to zero, one per cycle.
    assign clearing  = (clr_cnt_reg != CNT_W'(TABLE_DEPTH));
    assign init_done = !clearing;
    assign mem_we    = clearing || wr_en;
    assign mem_waddr = clearing ? clr_cnt_reg[IDX_W-1:0] : wr_addr;
    assign mem_wdata = clearing ? NULL_EXT : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/short_address_device_table.sv =====
// Short address device table: TABLE_DEPTH slots of 64-bit extended addresses, slot i
// answering to short address base_short_address + i. All slot data sits in one
// single-port-read synchronous memory. After reset the memory is swept to zero; until
// the sweep ends no command is taken (the base register can still be written).
// Allocate from the fresh region and any command rejected on range or null address go
// straight to the finish state; remove and lookup check their slot first. Search, add
// to a free slot and allocate once the high-water mark has reached TABLE_DEPTH walk the
// memory one slot per cycle through its read port. One command is in work at a time; a
// finished result waits in the output register while the next command is taken.
module short_address_device_table
    import sadt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // func [2:0], short_address [18:3], extended_address [82:19], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status [2:0], found_short_address [18:3], found_extended_address [82:19],
    // active_entries [91:83], zero fill above
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SHORT_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        IDLE,
        SLOT_CHK,
        SCAN,
        FIN
    } state_t;

    state_t state_reg;

    logic [SHORT_W-1:0]  base_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]    hwm_reg;

    logic [FUNC_W-1:0]   func_reg;
    logic [SHORT_W-1:0]  short_reg;
    logic [EXT_W-1:0]    ext_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SHORT_W-1:0]  fshort_reg;
    logic [EXT_W-1:0]    fext_reg;
    logic                fresh_reg;

    logic [CNT_W-1:0]    scan_cnt_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    scan_idx_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SHORT_W-1:0]  m_fshort_reg;
    logic [EXT_W-1:0]    m_fext_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic [FUNC_W-1:0]   s_func;
    logic [SHORT_W-1:0]  s_short;
    logic [EXT_W-1:0]    s_ext;
    logic [SHORT_W:0]    diff;
    logic                in_range;
    logic [IDX_W-1:0]    in_idx;
    logic                accept;
    logic                init_done;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [EXT_W-1:0]    rd_data;
    logic                wr_en;
    logic [EXT_W-1:0]    wr_data;

    logic                scan_more;
    logic                hit;
    logic                retire;
    logic                do_add;
    logic                do_remove;

    assign s_func  = s_tdata[FUNC_W-1:0];
    assign s_short = s_tdata[FUNC_W +: SHORT_W];
    assign s_ext   = s_tdata[FUNC_W + SHORT_W +: EXT_W];

    // Slot index is short minus base; a borrow means the address lies below the base.
    assign diff     = {1'b0, s_short} - {1'b0, base_reg};
    assign in_range = !diff[SHORT_W] && (diff[SHORT_W-1:0] < SHORT_W'(TABLE_DEPTH));
    assign in_idx   = diff[IDX_W-1:0];

    assign s_tready  = (state_reg == IDLE) && init_done;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign scan_more = (scan_cnt_reg != CNT_W'(TABLE_DEPTH));
    assign hit = pend_reg &&
                 ((func_reg == FUNC_ALLOC) ? (rd_data == NULL_EXT) : (rd_data == ext_reg));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = in_idx;
        if (state_reg == IDLE)
        begin
            rd_en = accept;
        end
        else if (state_reg == SCAN)
        begin
            rd_en   = scan_more && !hit;
            rd_addr = scan_cnt_reg[IDX_W-1:0];
        end
    end

    assign retire    = (state_reg == FIN) && (!m_valid_reg || m_tready);
    assign do_add    = (func_reg == FUNC_ADD) && (status_reg == STATUS_OK);
    assign do_remove = (func_reg == FUNC_REMOVE) && (status_reg == STATUS_OK);
    assign wr_en     = retire && (do_add || do_remove);
    assign wr_data   = do_add ? ext_reg : NULL_EXT;

    sadt_slot_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slot_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (idx_reg),
        .wr_data   (wr_data),
        .init_done (init_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            base_reg     <= BASE_RESET;
            count_reg    <= '0;
            hwm_reg      <= '0;
            func_reg     <= '0;
            short_reg    <= '0;
            ext_reg      <= '0;
            idx_reg      <= '0;
            status_reg   <= STATUS_OK;
            fshort_reg   <= '0;
            fext_reg     <= '0;
            fresh_reg    <= 1'b0;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_status_reg <= STATUS_OK;
            m_fshort_reg <= '0;
            m_fext_reg   <= '0;
            m_count_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end

            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        func_reg     <= s_func;
                        short_reg    <= s_short;
                        ext_reg      <= s_ext;
                        idx_reg      <= in_idx;
                        status_reg   <= STATUS_OK;
                        fshort_reg   <= '0;
                        fext_reg     <= '0;
                        fresh_reg    <= 1'b0;
                        scan_cnt_reg <= '0;
                        pend_reg     <= 1'b0;
                        state_reg    <= FIN;
                        case (s_func)
                            FUNC_ALLOC:
                            begin
                                if (hwm_reg != CNT_W'(TABLE_DEPTH))
                                begin
                                    fshort_reg <= base_reg + SHORT_W'(hwm_reg);
                                    fresh_reg  <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= SCAN;
                                end
                            end
                            FUNC_ADD:
                            begin
                                if (!in_range)
                                begin
                                    status_reg <= STATUS_RANGE;
                                end
                                else if (s_ext == NULL_EXT)
                                begin
                                    status_reg <= STATUS_NULL;
                                end
                                else
                                begin
                                    state_reg <= SLOT_CHK;
                                end
                            end
                            FUNC_REMOVE, FUNC_LOOKUP:
                            begin
                                if (!in_range)
                                begin
                                    status_reg <= STATUS_RANGE;
                                end
                                else
                                begin
                                    state_reg <= SLOT_CHK;
                                end
                            end
                            FUNC_SEARCH:
                            begin
                                if (s_ext == NULL_EXT)
                                begin
                                    status_reg <= STATUS_NULL;
                                end
                                else
                                begin
                                    state_reg <= SCAN;
                                end
                            end
                            default:
                            begin
                                status_reg <= STATUS_RANGE;
                            end
                        endcase
                    end
                end

                SLOT_CHK:
                begin
                    state_reg <= FIN;
                    if (rd_data == NULL_EXT)
                    begin
                        if (func_reg == FUNC_ADD)
                        begin
                            // The slot is free; make sure the address is not stored elsewhere.
                            state_reg <= SCAN;
                        end
                        else
                        begin
                            status_reg <= STATUS_NOT_FOUND;
                        end
                    end
                    else if (func_reg == FUNC_ADD)
                    begin
                        status_reg <= STATUS_SHORT_USED;
                    end
                    else
                    begin
                        fshort_reg <= short_reg;
                        if (func_reg == FUNC_LOOKUP)
                        begin
                            fext_reg <= rd_data;
                        end
                    end
                end

                SCAN:
                begin
                    if (hit)
                    begin
                        state_reg <= FIN;
                        if (func_reg == FUNC_ADD)
                        begin
                            status_reg <= STATUS_EXT_USED;
                        end
                        else
                        begin
                            fshort_reg <= base_reg + SHORT_W'(scan_idx_reg);
                        end
                    end
                    else if (!scan_more)
                    begin
                        state_reg <= FIN;
                        case (func_reg)
                            FUNC_ALLOC:
                            begin
                                status_reg <= STATUS_FULL;
                            end
                            FUNC_ADD:
                            begin
                                fshort_reg <= short_reg;
                            end
                            default:
                            begin
                                status_reg <= STATUS_NOT_FOUND;
                            end
                        endcase
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                        scan_idx_reg <= scan_cnt_reg[IDX_W-1:0];
                        pend_reg     <= 1'b1;
                    end
                end

                FIN:
                begin
                    if (retire)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_fshort_reg <= fshort_reg;
                        m_fext_reg   <= fext_reg;
                        m_count_reg  <= count_reg;
                        if (do_add)
                        begin
                            count_reg   <= count_reg + COUNT_W'(1);
                            m_count_reg <= count_reg + COUNT_W'(1);
                        end
                        else if (do_remove)
                        begin
                            count_reg   <= count_reg - COUNT_W'(1);
                            m_count_reg <= count_reg - COUNT_W'(1);
                        end
                        if (fresh_reg)
                        begin
                            hwm_reg <= hwm_reg + CNT_W'(1);
                        end
                        state_reg <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), m_count_reg, m_fext_reg,
                       m_fshort_reg, m_status_reg};

endmodule
